// ===== sv/quota_table_engine_assert.svh =====
// assertion helpers for the quota table engine
`ifndef QUOTA_TABLE_ENGINE_ASSERT_SVH
`define QUOTA_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication
`define QTE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/qte_pkg.sv =====
`default_nettype none
package qte_pkg;

   localparam int ENTRIES     = 256;
   localparam int QUOTA_TYPES = 2;
   localparam int IDX_W       = $clog2(ENTRIES);
   localparam int TYPE_W      = 1;

   typedef enum logic [2:0] {
      OP_CHECK_SPACE   = 3'd0,
      OP_CHECK_INODE   = 3'd1,
      OP_ACCOUNT_SPACE = 3'd2,
      OP_INODE_CREATE  = 3'd3,
      OP_INODE_REMOVE  = 3'd4,
      OP_SET           = 3'd5,
      OP_GET           = 3'd6,
      OP_GET_NEXT      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EXCEEDED = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_APPLY,
      S_RESP
   } state_type;

   typedef struct packed {
      logic        used;
      logic [31:0] id;
      logic [63:0] space_hard;
      logic [63:0] space_soft;
      logic [63:0] space_used;
      logic [63:0] files_hard;
      logic [63:0] files_soft;
      logic [63:0] files_used;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type entry;
   } wb_type;

   typedef struct packed {
      op_type              operation;
      logic [31:0]         user_id;
      logic [31:0]         group_id;
      logic [TYPE_W-1:0]   quota_type;
      logic [31:0]         target_id;
      logic signed [63:0]  byte_amount;
      logic [63:0]         block_hard;
      logic [63:0]         block_soft;
      logic [63:0]         inode_hard;
      logic [63:0]         inode_soft;
      logic [63:0]         current_inodes;
      logic [1:0]          limit_mask;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] entry_id;
      logic [63:0] out_block_hard;
      logic [63:0] out_block_soft;
      logic [63:0] out_space_used;
      logic [63:0] out_inode_hard;
      logic [63:0] out_inode_soft;
      logic [63:0] out_inodes_used;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/qte_cell.sv =====
`default_nettype none
module qte_cell
   import qte_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire entry_type d,
   output entry_type      q
);

   logic      used_ff;
   entry_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= d.used;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= d;
   end

   always_comb begin
      q      = data_ff;
      q.used = used_ff;
   end

endmodule
`default_nettype wire

// ===== sv/qte_ring.sv =====
`default_nettype none
module qte_ring
   import qte_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire wb_type wb,
   output entry_type   head
);

   entry_type q [ENTRIES];
   entry_type d [ENTRIES];

   genvar i;
   generate
      for (i = 0; i < ENTRIES; i++) begin : g_cell
         if (i == ENTRIES - 1) begin : g_tail
            assign d[i] = wb.en ? wb.entry : q[0];
         end else begin : g_mid
            assign d[i] = q[i+1];
         end
         qte_cell u_cell (
            .clock (clock),
            .reset (reset),
            .d     (d[i]),
            .q     (q[i])
         );
      end
   endgenerate

   assign head = q[0];

endmodule
`default_nettype wire

// ===== sv/quota_table_engine.sv =====
// channel   direction  ports                       handshake
// request   in         start, busy, req_data       taken when start and not busy
// response  out        rsp_valid, rsp_data         one-cycle strobe, no stall
// config    in         csr_write_en, csr_write_data written on any enabled edge
//
// each table is a ring of ENTRIES cells that rotates one slot per cycle
// an operation makes a full rotation to search; one that writes then waits until
// the chosen slot is at the head
// reset clears every used bit at once; no clearing pass
// the response word cannot be stalled and busy stays high until it has been shown
`default_nettype none
`include "quota_table_engine_assert.svh"
module quota_table_engine
   import qte_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   output rsp_type         rsp_data,
   input  wire logic       csr_write_en,
   input  wire logic [1:0] csr_write_data
);

   state_type            state_ff, state_in;
   req_type              req_ff;
   logic [1:0]           enable_ff;
   logic [IDX_W-1:0]     head_idx_ff;
   logic [IDX_W-1:0]     scan_cnt_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [QUOTA_TYPES-1:0] hit_ff, free_ff, pend_ff, alloc_ff;
   logic [QUOTA_TYPES-1:0] act, need_write, space_deny, inode_deny, wb_hit;
   logic [IDX_W-1:0]       hit_idx_ff  [QUOTA_TYPES];
   logic [IDX_W-1:0]       free_idx_ff [QUOTA_TYPES];
   logic [IDX_W-1:0]       tgt_idx_ff  [QUOTA_TYPES];
   entry_type              hit_entry_ff [QUOTA_TYPES];
   entry_type              head         [QUOTA_TYPES];
   wb_type                 wb           [QUOTA_TYPES];

   logic        accept;
   logic        owner_op;
   logic        type_ok;
   logic [63:0] amount;

   assign accept   = start && (state_ff == S_IDLE);
   assign owner_op = req_ff.operation inside {[OP_CHECK_SPACE:OP_INODE_REMOVE]};
   assign type_ok  = (32'(req_ff.quota_type) < 32'(QUOTA_TYPES));
   assign amount   = $unsigned(req_ff.byte_amount);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 2'b00;
      end else if (csr_write_en) begin
         enable_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_idx_ff <= '0;
      end else if (head_idx_ff == IDX_W'(ENTRIES - 1)) begin
         head_idx_ff <= '0;
      end else begin
         head_idx_ff <= head_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == S_DECIDE) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         scan_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_SCAN) begin
            scan_cnt_ff <= scan_cnt_ff + IDX_W'(1);
         end else begin
            scan_cnt_ff <= '0;
         end
      end
   end

   genvar t;
   generate
      for (t = 0; t < QUOTA_TYPES; t++) begin : g_type
         logic [31:0] key;
         logic        qual;
         entry_type   base;
         entry_type   upd;
         logic [63:0] mag;

         assign key = owner_op ? ((t == 0) ? req_ff.user_id : req_ff.group_id)
                               : req_ff.target_id;
         assign act[t] = owner_op ? enable_ff[t]
                                  : (type_ok && (req_ff.quota_type == TYPE_W'(t)));
         assign qual = head[t].used &&
                       ((req_ff.operation == OP_GET_NEXT) ? (head[t].id >= key)
                                                          : (head[t].id == key));

         always_ff @(posedge clock) begin
            if (reset) begin
               hit_ff[t]  <= 1'b0;
               free_ff[t] <= 1'b0;
            end else if (accept) begin
               hit_ff[t]  <= 1'b0;
               free_ff[t] <= 1'b0;
            end else if (state_ff == S_SCAN && act[t]) begin
               if (qual && (!hit_ff[t] || head_idx_ff < hit_idx_ff[t])) begin
                  hit_ff[t] <= 1'b1;
               end
               if (!head[t].used && (!free_ff[t] || head_idx_ff < free_idx_ff[t])) begin
                  free_ff[t] <= 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (state_ff == S_SCAN && act[t]) begin
               if (qual && (!hit_ff[t] || head_idx_ff < hit_idx_ff[t])) begin
                  hit_idx_ff[t]   <= head_idx_ff;
                  hit_entry_ff[t] <= head[t];
               end
               if (!head[t].used && (!free_ff[t] || head_idx_ff < free_idx_ff[t])) begin
                  free_idx_ff[t] <= head_idx_ff;
               end
            end
            if (state_ff == S_DECIDE) begin
               tgt_idx_ff[t] <= hit_ff[t] ? hit_idx_ff[t] : free_idx_ff[t];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               pend_ff[t]  <= 1'b0;
               alloc_ff[t] <= 1'b0;
            end else if (state_ff == S_DECIDE) begin
               pend_ff[t]  <= need_write[t];
               alloc_ff[t] <= !hit_ff[t];
            end else if (wb_hit[t]) begin
               pend_ff[t] <= 1'b0;
            end
         end

         always_comb begin
            case (req_ff.operation)
               OP_ACCOUNT_SPACE: need_write[t] = act[t] && (amount != 64'd0) &&
                                                 (hit_ff[t] || free_ff[t]);
               OP_INODE_CREATE:  need_write[t] = act[t] && (hit_ff[t] || free_ff[t]);
               OP_INODE_REMOVE:  need_write[t] = act[t] && hit_ff[t];
               OP_SET:           need_write[t] = act[t] && (hit_ff[t] || free_ff[t]);
               default:          need_write[t] = 1'b0;
            endcase
         end

         assign space_deny[t] = act[t] && hit_ff[t] &&
                                (hit_entry_ff[t].space_hard != 64'd0) &&
                                ((hit_entry_ff[t].space_used >= hit_entry_ff[t].space_hard) ||
                                 (amount > hit_entry_ff[t].space_hard -
                                           hit_entry_ff[t].space_used));
         assign inode_deny[t] = act[t] && hit_ff[t] &&
                                (hit_entry_ff[t].files_hard != 64'd0) &&
                                (hit_entry_ff[t].files_used >= hit_entry_ff[t].files_hard);

         assign wb_hit[t] = (state_ff == S_APPLY) && pend_ff[t] &&
                            (head_idx_ff == tgt_idx_ff[t]);
         assign mag = 64'd0 - amount;

         always_comb begin
            if (alloc_ff[t]) begin
               base      = '0;
               base.used = 1'b1;
               base.id   = key;
            end else begin
               base = head[t];
            end
            upd = base;
            case (req_ff.operation)
               OP_ACCOUNT_SPACE: begin
                  if (amount[63] && (mag > base.space_used)) begin
                     upd.space_used = 64'd0;
                  end else begin
                     upd.space_used = base.space_used + amount;
                  end
               end
               OP_INODE_CREATE: begin
                  upd.files_used = base.files_used + 64'd1;
               end
               OP_INODE_REMOVE: begin
                  if (base.files_used != 64'd0) begin
                     upd.files_used = base.files_used - 64'd1;
                  end
                  if (amount > base.space_used) begin
                     upd.space_used = 64'd0;
                  end else begin
                     upd.space_used = base.space_used - amount;
                  end
               end
               OP_SET: begin
                  if (req_ff.limit_mask[0]) begin
                     upd.space_hard = req_ff.block_hard;
                     upd.space_soft = req_ff.block_soft;
                  end
                  if (req_ff.limit_mask[1]) begin
                     upd.files_hard = req_ff.inode_hard;
                     upd.files_soft = req_ff.inode_soft;
                  end
                  upd.space_used = amount;
                  upd.files_used = req_ff.current_inodes;
               end
               default: begin
                  upd = base;
               end
            endcase
         end

         assign wb[t].en    = wb_hit[t];
         assign wb[t].entry = upd;

         qte_ring u_ring (
            .clock (clock),
            .reset (reset),
            .wb    (wb[t]),
            .head  (head[t])
         );
      end
   endgenerate

   always_comb begin
      rsp_in = '0;
      if (!owner_op && !type_ok) begin
         rsp_in.status = ST_NOT_FOUND;
      end else begin
         case (req_ff.operation)
            OP_CHECK_SPACE: begin
               if (amount != 64'd0 && space_deny != '0) begin
                  rsp_in.status = ST_EXCEEDED;
               end
            end
            OP_CHECK_INODE: begin
               if (inode_deny != '0) begin
                  rsp_in.status = ST_EXCEEDED;
               end
            end
            OP_SET: begin
               if (!hit_ff[req_ff.quota_type] && !free_ff[req_ff.quota_type]) begin
                  rsp_in.status = ST_FULL;
               end
            end
            OP_GET, OP_GET_NEXT: begin
               if (hit_ff[req_ff.quota_type]) begin
                  if (req_ff.operation == OP_GET_NEXT) begin
                     rsp_in.entry_id = hit_entry_ff[req_ff.quota_type].id;
                  end
                  rsp_in.out_block_hard  = hit_entry_ff[req_ff.quota_type].space_hard;
                  rsp_in.out_block_soft  = hit_entry_ff[req_ff.quota_type].space_soft;
                  rsp_in.out_space_used  = hit_entry_ff[req_ff.quota_type].space_used;
                  rsp_in.out_inode_hard  = hit_entry_ff[req_ff.quota_type].files_hard;
                  rsp_in.out_inode_soft  = hit_entry_ff[req_ff.quota_type].files_soft;
                  rsp_in.out_inodes_used = hit_entry_ff[req_ff.quota_type].files_used;
               end else if (req_ff.operation == OP_GET_NEXT) begin
                  rsp_in.status = ST_NOT_FOUND;
               end
            end
            default: begin
               rsp_in.status = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_cnt_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = (need_write != '0) ? S_APPLY : S_RESP;
         end
         S_APPLY: begin
            if ((pend_ff & ~wb_hit) == '0) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      rsp_data  = rsp_ff;
   end

   `QTE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
   `QTE_ASSERT_NXT(a_resp_idle, rsp_valid, !busy && !rsp_valid, "response not a single strobe")
   `QTE_ASSERT_IMP(a_apply_pending, state_ff == S_APPLY, pend_ff != '0, "apply with no write")
   `QTE_ASSERT_IMP(a_resp_source, rsp_valid,
      $past(state_ff) == S_DECIDE || $past(state_ff) == S_APPLY, "response out of order")

endmodule
`default_nettype wire
